### src/bsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and codes for the bounded stack
// word formats of both channels, request kinds and status codes
// ----------------------------------------------------------------------------
package bsp_pkg;

  // request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // capacity register
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } bsp_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
    logic               is_palindrome;
    logic [4:0]         fill_count;
  } bsp_out_t;

endpackage

### src/bsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_ram: generic synchronous ram
// one write port, two read ports, read data registered
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_a,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/bsp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_cfg: apb register block
// holds the capacity register, written and read over the apb port
// ----------------------------------------------------------------------------
module bsp_cfg
  import bsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CAP_W-1:0] capacity
);

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;
  logic             hit;

  // register index 0 lives at byte address 0
  assign hit = (paddr[2] == 1'b0);

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && hit) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata   = hit ? {{(32-CAP_W){1'b0}}, cap_r} : 32'd0;
  assign pready   = 1'b1;
  assign capacity = cap_r;

endmodule

### src/bounded_stack_palindrome_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_palindrome_check: bounded lifo stack with a palindrome check
// a push, a rejected request, an unused kind or a check of fewer than two
//   entries writes its result into the output register at acceptance; a pop
//   reads the top entry first; a check of n >= 2 entries walks the pairs, both
//   ends of a pair read together, one pair per cycle; one word at a time:
//   a new one is taken only while idle and with the output register free
// reset: synchronous active-low rst_n empties the stack, capacity back to 16
// ----------------------------------------------------------------------------
module bounded_stack_palindrome_check
  import bsp_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  bsp_in_t    in_data,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output bsp_out_t   out_data,
  // apb configuration port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;   // waiting for the top entry
  localparam logic [1:0] S_CHECK = 2'd2;   // walking entry pairs

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    lo_r, lo_nxt;
  logic [AW-1:0]    hi_r, hi_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;   // read data of a pair is due
  logic             match_r, match_nxt;
  logic             out_valid_r, out_valid_nxt;
  bsp_out_t         out_data_r, out_data_nxt;

  logic [CAP_W-1:0] capacity;
  logic             accept;
  logic             slot_free;
  logic             push_ok;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W+4:0] cnt_ext;
  logic [4:0]       fill5;
  logic             issue;

  // ram ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr_a;
  logic [AW-1:0]    ram_raddr_b;
  logic [31:0]      ram_rdata_a;
  logic [31:0]      ram_rdata_b;

  bsp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bsp_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_data.push_value),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // the output register is free if empty or being taken this cycle, so a
  // new request can come in while the last result is still on its way out
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // room left: below both the programmed capacity and the built depth
  assign push_ok = (CMP_W'(cnt_r) < CMP_W'(capacity)) &&
                   (CMP_W'(cnt_r) < CMP_W'(DEPTH));

  assign cnt_dec = cnt_r - 1'b1;

  // a push writes the new top at the edge it is accepted
  assign ram_we    = accept && (in_data.req_type == REQ_PUSH) && push_ok;
  assign ram_waddr = cnt_r[AW-1:0];

  // port a: the top entry for a pop, the low pointer while checking
  assign ram_raddr_a = (state_r == S_CHECK) ? lo_r : cnt_dec[AW-1:0];
  assign ram_raddr_b = hi_r;

  // pairs still to be read while checking
  assign issue = (state_r == S_CHECK) && (lo_r < hi_r);

  // fill count reported modulo 32
  assign cnt_ext = (CNT_W+5)'(cnt_nxt);
  assign fill5   = cnt_ext[4:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cmp_vld_nxt   = 1'b0;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt.status        = STAT_DONE;
          out_data_nxt.pop_value     = '0;
          out_data_nxt.is_palindrome = 1'b0;
          case (in_data.req_type)
            REQ_PUSH: begin
              out_valid_nxt = 1'b1;
              if (push_ok) begin
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                out_data_nxt.status = STAT_OVERFLOW;
              end
            end
            REQ_POP: begin
              if (cnt_r != '0) begin
                // top entry read is under way, result registered in S_POP
                cnt_nxt   = cnt_dec;
                state_nxt = S_POP;
              end else begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = STAT_UNDERFLOW;
              end
            end
            REQ_CHECK: begin
              if (cnt_r == '0) begin
                // empty stack is not a palindrome
                out_valid_nxt = 1'b1;
              end else if (cnt_r == CNT_W'(1)) begin
                // single entry reads the same both ways
                out_valid_nxt              = 1'b1;
                out_data_nxt.is_palindrome = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_dec[AW-1:0];
                match_nxt = 1'b1;
                state_nxt = S_CHECK;
              end
            end
            default: begin
              // unused request kind: no change, plain done
              out_valid_nxt = 1'b1;
            end
          endcase
          out_data_nxt.fill_count = fill5;
        end
      end

      S_POP: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = STAT_DONE;
        out_data_nxt.pop_value  = ram_rdata_a;
        out_data_nxt.fill_count = fill5;
        state_nxt               = S_IDLE;
      end

      S_CHECK: begin
        // issue the next pair while comparing the one read last cycle
        if (issue) begin
          lo_nxt      = lo_r + 1'b1;
          hi_nxt      = hi_r - 1'b1;
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          match_nxt = match_r && (ram_rdata_a == ram_rdata_b);
        end
        if (!issue && cmp_vld_r) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = STAT_DONE;
          out_data_nxt.pop_value     = '0;
          out_data_nxt.is_palindrome = match_r && (ram_rdata_a == ram_rdata_b);
          out_data_nxt.fill_count    = fill5;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk pointers need no reset
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
